// File: src/urbe_pkg.sv
package urbe_pkg;

    localparam int RX_DEPTH_DEF = 16;
    localparam int TX_DEPTH_DEF = 16;
    localparam int CNT_W        = 4;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_RECV   = 2'd2,
        MODE_TXDONE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic             read_valid;
        logic [7:0]       read_byte;
        logic             write_accepted;
        logic             line_send;
        logic [7:0]       line_byte;
        logic             tx_busy;
        logic [CNT_W-1:0] rx_count;
        logic [CNT_W-1:0] tx_pending;
        logic [CNT_W-1:0] tx_free;
        logic [7:0]       overflow_count;
    } t_out_beat;

    typedef struct packed {
        logic             read_valid;
        logic [7:0]       read_byte;
        logic [CNT_W-1:0] rx_count;
        logic [7:0]       overflow_count;
    } t_rx_stat;

    typedef struct packed {
        logic             write_accepted;
        logic             line_send;
        logic [7:0]       line_byte;
        logic             tx_busy;
        logic [CNT_W-1:0] tx_pending;
        logic [CNT_W-1:0] tx_free;
    } t_tx_stat;

endpackage

// File: src/urbe_rx_ring.sv
module urbe_rx_ring import urbe_pkg::*; #(
    parameter int RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_beat i_beat,
    output t_rx_stat o_stat
);

    localparam int PW = $clog2(RX_DEPTH);

    logic [7:0]    r_mem [RX_DEPTH];
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [7:0]    r_ovf;
    logic          r_rd_hit;
    logic [7:0]    r_rd_data;

    logic [PW-1:0] n_head;
    logic [PW-1:0] n_tail;
    logic [7:0]    n_ovf;
    logic          do_read;
    logic          do_recv;
    logic [PW-1:0] count;

    always_comb begin
        do_read = i_fire && (i_beat.mode == MODE_READ) && (r_head != r_tail);
        do_recv = i_fire && (i_beat.mode == MODE_RECV);
        n_head  = do_read ? r_head + PW'(1) : r_head;
        n_tail  = do_recv ? r_tail + PW'(1) : r_tail;
        n_ovf   = (do_recv && (n_tail == r_head)) ? r_ovf + 8'd1 : r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_ovf    <= '0;
            r_rd_hit <= 1'b0;
        end else if (i_fire) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ovf    <= n_ovf;
            r_rd_hit <= do_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_recv) begin
            r_mem[r_tail] <= i_beat.data_byte;
        end
        if (do_read) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign count = r_tail - r_head;

    always_comb begin
        o_stat.read_valid     = r_rd_hit;
        o_stat.read_byte      = r_rd_hit ? r_rd_data : 8'd0;
        o_stat.rx_count       = CNT_W'(count);
        o_stat.overflow_count = r_ovf;
    end

    a_ovf_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_recv && (n_tail == r_head) |=> r_ovf == 8'($past(r_ovf) + 8'd1))
        else $error("overflow count did not advance on receive overrun");

    a_ovf_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_recv && (n_tail == r_head)) |=> r_ovf == $past(r_ovf))
        else $error("overflow count changed without an overrun");

endmodule

// File: src/urbe_tx_ring.sv
module urbe_tx_ring import urbe_pkg::*; #(
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_beat i_beat,
    output t_tx_stat o_stat
);

    localparam int            PW   = $clog2(TX_DEPTH);
    localparam logic [PW-1:0] MASK = PW'(TX_DEPTH - 1);

    logic [7:0]    r_mem [TX_DEPTH];
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic          r_active;
    logic          r_wr_ok;
    logic          r_send;
    logic          r_sel_mem;
    logic [7:0]    r_line_data;
    logic [7:0]    r_rd_data;

    logic [PW-1:0] n_tail;
    logic          wr_ok;
    logic          wr_direct;
    logic          wr_queue;
    logic          done_pop;
    logic          done_idle;
    logic [PW-1:0] pending;

    always_comb begin
        n_tail    = r_tail + PW'(1);
        wr_ok     = i_fire && (i_beat.mode == MODE_WRITE) && (n_tail != r_head);
        wr_direct = wr_ok && !r_active;
        wr_queue  = wr_ok && r_active;
        done_pop  = i_fire && (i_beat.mode == MODE_TXDONE) && (r_tail != r_head);
        done_idle = i_fire && (i_beat.mode == MODE_TXDONE) && (r_tail == r_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_active  <= 1'b0;
            r_wr_ok   <= 1'b0;
            r_send    <= 1'b0;
            r_sel_mem <= 1'b0;
        end else if (i_fire) begin
            r_wr_ok   <= wr_ok;
            r_send    <= wr_direct || done_pop;
            r_sel_mem <= done_pop;
            if (wr_queue) begin
                r_tail <= n_tail;
            end
            if (done_pop) begin
                r_head <= r_head + PW'(1);
            end
            if (wr_direct) begin
                r_active <= 1'b1;
            end else if (done_idle) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_queue) begin
            r_mem[r_tail] <= i_beat.data_byte;
        end
        if (done_pop) begin
            r_rd_data <= r_mem[r_head];
        end
        if (wr_direct) begin
            r_line_data <= i_beat.data_byte;
        end
    end

    assign pending = r_tail - r_head;

    always_comb begin
        o_stat.write_accepted = r_wr_ok;
        o_stat.line_send      = r_send;
        o_stat.line_byte      = !r_send ? 8'd0 : (r_sel_mem ? r_rd_data : r_line_data);
        o_stat.tx_busy        = r_active;
        o_stat.tx_pending     = CNT_W'(pending);
        o_stat.tx_free        = CNT_W'(MASK - pending);
    end

    a_queue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail != r_head) |-> r_active)
        else $error("queued bytes while transmitter idle");

    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_send |-> r_active)
        else $error("byte handed to line with busy flag clear");

endmodule

// File: src/uart_ring_buffer_engine.sv
// An input beat is held in the input register, then its result goes to the result register.
// One beat per cycle unless stalled; the head/tail pointer update is a single narrow add.
// Reset: synchronous active-low i_rst_n clears pointers, overflow count, busy flag
// and both pipeline valids; buffer contents stay undefined until written.
module uart_ring_buffer_engine import urbe_pkg::*; #(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic     r_a_valid;
    t_in_beat r_a_beat;
    logic     r_b_valid;
    logic     move;
    logic     in_fire;
    t_rx_stat rx_stat;
    t_tx_stat tx_stat;

    assign move       = r_a_valid && (!r_b_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !move;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_a_valid <= 1'b1;
            end else if (move) begin
                r_a_valid <= 1'b0;
            end
            if (move) begin
                r_b_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_beat <= i_in_beat;
        end
    end

    urbe_rx_ring #(
        .RX_DEPTH(RX_DEPTH)
    ) u_rx (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (move),
        .i_beat (r_a_beat),
        .o_stat (rx_stat)
    );

    urbe_tx_ring #(
        .TX_DEPTH(TX_DEPTH)
    ) u_tx (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (move),
        .i_beat (r_a_beat),
        .o_stat (tx_stat)
    );

    assign o_out_valid = r_b_valid;

    always_comb begin
        o_out_beat.read_valid     = rx_stat.read_valid;
        o_out_beat.read_byte      = rx_stat.read_byte;
        o_out_beat.write_accepted = tx_stat.write_accepted;
        o_out_beat.line_send      = tx_stat.line_send;
        o_out_beat.line_byte      = tx_stat.line_byte;
        o_out_beat.tx_busy        = tx_stat.tx_busy;
        o_out_beat.rx_count       = rx_stat.rx_count;
        o_out_beat.tx_pending     = tx_stat.tx_pending;
        o_out_beat.tx_free        = tx_stat.tx_free;
        o_out_beat.overflow_count = rx_stat.overflow_count;
    end

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_b_valid && i_out_stall))
        else $error("input stalled while result register free");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_a_valid)
        else $error("pending beat dropped while stalled");

endmodule
